// File: rtl/core/nmb_pkg.sv
// Shared types, constants and tables for the boat motion step block.
`timescale 1ns / 1ps
package nmb_pkg;

  localparam int POSITION_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = 1;

  localparam int PI_Q13       = 25736;
  localparam int TWO_PI_Q13   = 51472;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q16  = 102944;
  localparam int CORDIC_X0    = 39797;
  localparam int CORDIC_STEPS = 16;

  // ceil(2^29 / 125): exact floor(n / 125) for n below 2^22
  localparam logic [22:0] RECIP_125 = 23'd4294968;

  localparam logic [2:0] CFG_STEP_TIME  = 3'd0;
  localparam logic [2:0] CFG_RUDDER_K   = 3'd1;
  localparam logic [2:0] CFG_INV_TC     = 3'd2;
  localparam logic [2:0] CFG_MAX_RUDDER = 3'd3;
  localparam logic [2:0] CFG_MAX_SPEED  = 3'd4;

  localparam logic [15:0] RST_STEP_TIME  = 16'd655;
  localparam logic [12:0] RST_RUDDER_K   = 13'd2048;
  localparam logic [15:0] RST_INV_TC     = 16'd2048;
  localparam logic [13:0] RST_MAX_RUDDER = 14'd5004;
  localparam logic [14:0] RST_MAX_SPEED  = 15'd12288;

  typedef struct packed {
    logic [15:0] step_time;
    logic [12:0] rudder_gain;
    logic [15:0] inv_tc;
    logic [13:0] max_rudder;
    logic [14:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic       rud_neg;
    logic [8:0] rud_mag;
    logic [9:0] thr;
  } job_t;

  function automatic logic [16:0] atan_val(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/nmb_front.sv
// Input side: clamps pulse widths and splits the rudder into sign and magnitude.
`timescale 1ns / 1ps
module nmb_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [11:0]     rudder_pwm,
  input  logic [11:0]     throttle_pwm,
  input  logic            q_full,
  output logic            q_push,
  output nmb_pkg::job_t   q_data
);

  logic [11:0] rud_c;
  logic [11:0] thr_c;
  logic [11:0] rud_d;
  logic [11:0] thr_d;

  always_comb begin
    if (rudder_pwm < 12'd1000) begin
      rud_c = 12'd1000;
    end else if (rudder_pwm > 12'd2000) begin
      rud_c = 12'd2000;
    end else begin
      rud_c = rudder_pwm;
    end
    if (throttle_pwm < 12'd1000) begin
      thr_c = 12'd1000;
    end else if (throttle_pwm > 12'd2000) begin
      thr_c = 12'd2000;
    end else begin
      thr_c = throttle_pwm;
    end
    q_data.rud_neg = rud_c < 12'd1500;
    rud_d = q_data.rud_neg ? (12'd1500 - rud_c) : (rud_c - 12'd1500);
    thr_d = thr_c - 12'd1000;
    q_data.rud_mag = rud_d[8:0];
    q_data.thr     = thr_d[9:0];
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: rtl/core/nmb_queue.sv
// Two-entry queue between the input side and the step engine.
`timescale 1ns / 1ps
module nmb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nmb_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output nmb_pkg::job_t pop_data,
  output logic          empty
);

  nmb_pkg::job_t                  mem [nmb_pkg::QUEUE_DEPTH];
  logic [nmb_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [nmb_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [nmb_pkg::QPTR_BITS:0]    count;

  assign full     = count == (nmb_pkg::QPTR_BITS+1)'(nmb_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/nmb_back.sv
// Step engine: Nomoto yaw update, heading wrap, CORDIC, dividers and position.
`timescale 1ns / 1ps
module nmb_back (
  input  logic                clk,
  input  logic                rst,
  input  nmb_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  nmb_pkg::job_t       q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  heading,
  output logic signed [15:0]  yaw_rate,
  output logic signed [15:0]  speed_north,
  output logic signed [15:0]  speed_east,
  output logic signed [31:0]  offset_north,
  output logic signed [31:0]  offset_east
);

  localparam int PB = nmb_pkg::POSITION_BITS;
  localparam int WB = ((PB > 32) ? PB : 32) + 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_MUL   = 8'b00000010,
    ST_HEAD  = 8'b00000100,
    ST_ITER  = 8'b00001000,
    ST_KD    = 8'b00010000,
    ST_ERR   = 8'b00100000,
    ST_SCALE = 8'b01000000,
    ST_UPD   = 8'b10000000
  } state_t;

  state_t               state;
  nmb_pkg::job_t        job;
  logic [23:0]          pm;
  logic [24:0]          ps;
  logic signed [32:0]   yp;
  logic signed [15:0]   heading_r;
  logic signed [15:0]   yaw_r;
  logic signed [PB-1:0] north_acc;
  logic signed [PB-1:0] east_acc;
  logic [4:0]           cnt;
  logic [13:0]          quo_a;
  logic [15:0]          quo_b;
  logic signed [19:0]   cx;
  logic signed [19:0]   cy;
  logic signed [19:0]   cz;
  logic                 neg;
  logic signed [16:0]   kd;
  logic signed [35:0]   pn;
  logic signed [35:0]   pe;
  logic signed [33:0]   p1;
  logic signed [15:0]   vn;
  logic signed [15:0]   ve;
  logic signed [49:0]   p2;
  logic signed [32:0]   dn;
  logic signed [32:0]   de;

  logic signed [32:0]   yp_rs;
  logic signed [17:0]   psi_sum;
  logic signed [17:0]   psi_w;
  logic signed [19:0]   z8;
  logic signed [19:0]   z0;
  logic                 neg0;
  logic [44:0]          prod_a;
  logic [44:0]          prod_b;
  logic [3:0]           ci;
  logic signed [19:0]   xs;
  logic signed [19:0]   ys;
  logic signed [19:0]   at;
  logic signed [14:0]   delta;
  logic signed [28:0]   kprod;
  logic signed [28:0]   kprod_r;
  logic signed [16:0]   speed_s;
  logic signed [19:0]   cos_v;
  logic signed [19:0]   sin_v;
  logic signed [35:0]   pn_r;
  logic signed [35:0]   pe_r;
  logic signed [49:0]   p2_r;
  logic signed [23:0]   r_sum;
  logic signed [15:0]   r_sat;
  logic signed [32:0]   dn_r;
  logic signed [32:0]   de_r;
  logic signed [PB:0]   n_sum;
  logic signed [PB:0]   e_sum;
  logic signed [PB-1:0] n_sat;
  logic signed [PB-1:0] e_sat;
  logic signed [WB-1:0] n_wide;
  logic signed [WB-1:0] e_wide;
  logic                 upd_go;

  function automatic logic signed [15:0] sat_v(input logic signed [35:0] p);
    logic signed [35:0] r;
    r = (p + 36'sd32768) >>> 16;
    if (r > 36'sd32767) begin
      return 16'sd32767;
    end else if (r < -36'sd32767) begin
      return -16'sd32767;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [PB-1:0] sat_pos(input logic signed [PB:0] v);
    logic signed [PB:0] hi;
    logic signed [PB:0] lo;
    hi = (PB+1)'({1'b0, {(PB-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[PB-1:0];
    end else if (v < lo) begin
      return lo[PB-1:0];
    end
    return v[PB-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] hi;
    logic signed [WB-1:0] lo;
    hi = WB'(33'sh0_7FFF_FFFF);
    lo = ~hi;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    yp_rs   = (yp + 33'sd32768) >>> 16;
    psi_sum = 18'(heading_r) + yp_rs[17:0];
    if (psi_sum > 18'sd25736) begin
      psi_w = psi_sum - 18'sd51472;
    end else if (psi_sum < -18'sd25736) begin
      psi_w = psi_sum + 18'sd51472;
    end else begin
      psi_w = psi_sum;
    end

    z8 = 20'(heading_r) <<< 3;
    if (z8 > 20'sd102944) begin
      z0   = z8 - 20'sd205887;
      neg0 = 1'b1;
    end else if (z8 < -20'sd102944) begin
      z0   = z8 + 20'sd205887;
      neg0 = 1'b1;
    end else begin
      z0   = z8;
      neg0 = 1'b0;
    end

    // n / 500 = (n >> 2) / 125, n / 1000 = (n >> 3) / 125
    prod_a = 45'(pm[23:2]) * 45'(nmb_pkg::RECIP_125);
    prod_b = 45'(ps[24:3]) * 45'(nmb_pkg::RECIP_125);

    ci = 4'(cnt - 5'd1);
    xs = cx >>> ci;
    ys = cy >>> ci;
    at = $signed(20'(nmb_pkg::atan_val(ci)));

    delta   = job.rud_neg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
    kprod   = $signed({1'b0, cfg.rudder_gain}) * delta;
    kprod_r = (kprod + 29'sd2048) >>> 12;
    speed_s = $signed({1'b0, quo_b});
    cos_v   = neg ? -cx : cx;
    sin_v   = neg ? -cy : cy;
    pn_r    = speed_s * cos_v;
    pe_r    = speed_s * sin_v;

    p2_r  = (p2 + 50'sd134217728) >>> 28;
    r_sum = 24'(yaw_r) + p2_r[23:0];
    if (r_sum > 24'sd32767) begin
      r_sat = 16'sh7FFF;
    end else if (r_sum < -24'sd32768) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r_sum[15:0];
    end

    dn_r   = (dn + 33'sd2048) >>> 12;
    de_r   = (de + 33'sd2048) >>> 12;
    n_sum  = (PB+1)'(north_acc) + (PB+1)'($signed(dn_r[21:0]));
    e_sum  = (PB+1)'(east_acc) + (PB+1)'($signed(de_r[21:0]));
    n_sat  = sat_pos(n_sum);
    e_sat  = sat_pos(e_sum);
    n_wide = WB'(n_sat);
    e_wide = WB'(e_sat);

    upd_go = !out_valid || out_ready;
    q_pop  = (state == ST_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job <= q_data;
      end
      ST_MUL: begin
        pm <= 24'(cfg.max_rudder) * 24'(job.rud_mag) + 24'd250;
        ps <= 25'(cfg.max_speed) * 25'(job.thr) + 25'd500;
        yp <= yaw_r * $signed({1'b0, cfg.step_time});
      end
      ST_HEAD: begin
        quo_a <= prod_a[42:29];
        quo_b <= prod_b[44:29];
      end
      ST_ITER: begin
        if (cnt == 5'd0) begin
          cx  <= 20'sd39797;
          cy  <= '0;
          cz  <= z0;
          neg <= neg0;
        end else if (cnt <= 5'd16) begin
          if (cz >= 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
        end
      end
      ST_KD: begin
        kd <= kprod_r[16:0];
        pn <= pn_r;
        pe <= pe_r;
      end
      ST_ERR: begin
        p1 <= 34'(18'(kd) - 18'(yaw_r)) * 34'($signed({1'b0, cfg.step_time}));
        vn <= sat_v(pn);
        ve <= sat_v(pe);
      end
      ST_SCALE: begin
        p2 <= 50'(p1) * 50'($signed({1'b0, cfg.inv_tc}));
        dn <= vn * $signed({1'b0, cfg.step_time});
        de <= ve * $signed({1'b0, cfg.step_time});
      end
      ST_UPD: begin
        if (upd_go) begin
          heading      <= heading_r;
          yaw_rate     <= r_sat;
          speed_north  <= vn;
          speed_east   <= ve;
          offset_north <= sat32(n_wide);
          offset_east  <= sat32(e_wide);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      heading_r <= '0;
      yaw_r     <= '0;
      north_acc <= '0;
      east_acc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          heading_r <= psi_w[15:0];
          cnt       <= '0;
          state     <= ST_ITER;
        end
        ST_ITER: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(nmb_pkg::CORDIC_STEPS)) begin
            state <= ST_KD;
          end
        end
        ST_KD: begin
          state <= ST_ERR;
        end
        ST_ERR: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_go) begin
            yaw_r     <= r_sat;
            north_acc <= n_sat;
            east_acc  <= e_sat;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/nomoto_boat_motion_step.sv
// Top level of the boat motion step: config registers, input side, queue, engine.
//
//   channel  | handshake              | beat
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_ready    | rudder_pwm, throttle_pwm
//   out      | out_valid / out_ready  | heading, yaw_rate, speed_*, offset_*
//   cfg      | cfg_we                 | cfg_index, cfg_data
//
// A beat passes through the engine in steps: pop, products, reciprocal divide by
// 500 and 1000 with the heading wrap, the CORDIC load and 16 rotations, then
// gain, error, scaling and the update step.
// Reset is synchronous and clears state, queue and output valid.
// A two-entry queue takes beats while the engine works; the engine waits in its
// last step while a finished result is not yet taken.
`timescale 1ns / 1ps
module nomoto_boat_motion_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        rudder_pwm,
  input  logic [11:0]        throttle_pwm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] heading,
  output logic signed [15:0] yaw_rate,
  output logic signed [15:0] speed_north,
  output logic signed [15:0] speed_east,
  output logic signed [31:0] offset_north,
  output logic signed [31:0] offset_east,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  nmb_pkg::cfg_t cfg;
  nmb_pkg::job_t push_data;
  nmb_pkg::job_t pop_data;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time   <= nmb_pkg::RST_STEP_TIME;
      cfg.rudder_gain <= nmb_pkg::RST_RUDDER_K;
      cfg.inv_tc      <= nmb_pkg::RST_INV_TC;
      cfg.max_rudder  <= nmb_pkg::RST_MAX_RUDDER;
      cfg.max_speed   <= nmb_pkg::RST_MAX_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        nmb_pkg::CFG_STEP_TIME:  cfg.step_time   <= cfg_data;
        nmb_pkg::CFG_RUDDER_K:   cfg.rudder_gain <= cfg_data[12:0];
        nmb_pkg::CFG_INV_TC:     cfg.inv_tc      <= cfg_data;
        nmb_pkg::CFG_MAX_RUDDER: cfg.max_rudder  <= cfg_data[13:0];
        nmb_pkg::CFG_MAX_SPEED:  cfg.max_speed   <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  nmb_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rudder_pwm   (rudder_pwm),
    .throttle_pwm (throttle_pwm),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  nmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  nmb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .heading      (heading),
    .yaw_rate     (yaw_rate),
    .speed_north  (speed_north),
    .speed_east   (speed_east),
    .offset_north (offset_north),
    .offset_east  (offset_east)
  );

endmodule
